// ===== rtl/msb_first_bit_packer_assert.svh =====
`ifndef MSB_FIRST_BIT_PACKER_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BPK_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bit packer check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define BPK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bit packer check failed");

`endif

// ===== rtl/bpk_pkg.sv =====
package bpk_pkg;

	// fixed field widths of the channels
	localparam int CODE_BITS  = 32;
	localparam int WIDTH_BITS = 6;
	localparam int BYTE_BITS  = 8;

	// widest code accepted, larger widths are clipped to this
	localparam logic [WIDTH_BITS-1:0] CODE_MAX = 6'd32;

	typedef logic [0:0] op_t;

	localparam op_t OP_WRITE = 1'b0;
	localparam op_t OP_FLUSH = 1'b1;

	// job queue status seen by producer and consumer
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ===== rtl/bpk_in_if.sv =====
interface bpk_in_if import bpk_pkg::*; ();
	logic                  valid;
	logic                  ready;
	op_t                   operation;
	logic [CODE_BITS-1:0]  code_value;
	logic [WIDTH_BITS-1:0] code_width;

	modport source (output valid, operation, code_value, code_width, input ready);
	modport sink   (input valid, operation, code_value, code_width, output ready);
endinterface

// ===== rtl/bpk_out_if.sv =====
interface bpk_out_if import bpk_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [BYTE_BITS-1:0] out_byte;
	logic                 last_byte;

	modport source (output valid, out_byte, last_byte, input ready);
	modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== rtl/bpk_queue.sv =====
module bpk_queue import bpk_pkg::*; #(
	parameter int W     = 40,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output qstat_t       qstat
);

	// pointers wrap naturally, so DEPTH is a power of two
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign qstat.full  = (cnt_q == CW'(DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign rdata       = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= AW'(wr_q + AW'(1));
			end
			if (pop) begin
				rd_q <= AW'(rd_q + AW'(1));
			end
			if (push && !pop) begin
				cnt_q <= CW'(cnt_q + CW'(1));
			end else if (pop && !push) begin
				cnt_q <= CW'(cnt_q - CW'(1));
			end
		end
	end

	`include "msb_first_bit_packer_assert.svh"

	`BPK_ASSERT_NOW(a_no_push_full, push, !qstat.full)
	`BPK_ASSERT_NOW(a_no_pop_empty, pop, !qstat.empty)

endmodule

// ===== rtl/bpk_front.sv =====
module bpk_front import bpk_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int NBW       = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	bpk_in_if.sink                   codes,
	input  qstat_t                   qstat,
	output logic                     push,
	output logic [WORD_BITS+NBW-1:0] job
);

	localparam int FW     = $clog2(WORD_BITS + CODE_BITS + 1);
	localparam int EW     = WORD_BITS + CODE_BITS;
	localparam int NBYTES = WORD_BITS / BYTE_BITS;

	logic [WORD_BITS-1:0] acc_q;
	logic [FW-1:0]        fill_q;

	logic                  accept;
	logic [WIDTH_BITS-1:0] w_clip;
	logic [CODE_BITS:0]    mask;
	logic [CODE_BITS-1:0]  code_m;
	logic [EW-1:0]         codex;
	logic [EW-1:0]         shifted;
	logic [FW-1:0]         sum;
	logic [FW-1:0]         fill_n;
	logic [FW-1:0]         round_up;
	logic [WORD_BITS-1:0]  acc_n;
	logic [WORD_BITS-1:0]  job_word;
	logic [NBW-1:0]        job_n;
	logic                  job_req;

	assign codes.ready = !qstat.full;
	assign accept      = codes.valid && codes.ready;
	assign push        = accept && job_req;
	assign job         = {job_word, job_n};

	// classify the word and work out the next accumulator
	always_comb begin
		w_clip   = (codes.code_width > CODE_MAX) ? CODE_MAX : codes.code_width;
		mask     = ~({(CODE_BITS + 1){1'b1}} << w_clip);
		code_m   = codes.code_value & mask[CODE_BITS-1:0];
		codex    = EW'(code_m);
		sum      = FW'(fill_q) + FW'(w_clip);
		fill_n   = fill_q;
		acc_n    = acc_q;
		shifted  = '0;
		round_up = FW'(fill_q + FW'(7)) >> 3;
		job_word = acc_q;
		job_n    = round_up[NBW-1:0];
		job_req  = 1'b0;
		if (codes.operation == OP_FLUSH) begin
			job_req = (fill_q != '0);
			acc_n   = '0;
			fill_n  = '0;
		end else if (w_clip != '0) begin
			if (sum > FW'(WORD_BITS)) begin
				// word overflows: top part of code completes it, rest starts the next
				fill_n   = FW'(sum - FW'(WORD_BITS));
				shifted  = codex >> fill_n;
				job_word = acc_q | shifted[WORD_BITS-1:0];
				job_n    = NBW'(NBYTES);
				job_req  = 1'b1;
				shifted  = codex << FW'(FW'(WORD_BITS) - fill_n);
				acc_n    = shifted[WORD_BITS-1:0];
			end else begin
				fill_n  = sum;
				shifted = codex << FW'(FW'(WORD_BITS) - sum);
				acc_n   = acc_q | shifted[WORD_BITS-1:0];
			end
		end
	end

	// packing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fill_q <= '0;
		end else if (accept) begin
			acc_q  <= acc_n;
			fill_q <= fill_n;
		end
	end

endmodule

// ===== rtl/bpk_back.sv =====
module bpk_back import bpk_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int NBW       = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [WORD_BITS+NBW-1:0] head,
	input  qstat_t                   qstat,
	output logic                     pop,
	bpk_out_if.source                stream
);

	localparam int NBYTES = WORD_BITS / BYTE_BITS;

	logic [WORD_BITS-1:0] word_q;
	logic [NBW-1:0]       rem_q;
	logic                 ov_q;
	logic [BYTE_BITS-1:0] byte_q;
	logic                 last_q;

	logic                 advance;
	logic                 emit;
	logic                 last;
	logic [WORD_BITS-1:0] cur_word;
	logic [NBW-1:0]       cur_rem;

	assign stream.valid     = ov_q;
	assign stream.out_byte  = byte_q;
	assign stream.last_byte = last_q;

	// output register is free or being taken this cycle
	assign advance = !ov_q || stream.ready;

	// current job: the one in progress, else the queue head
	always_comb begin
		if (rem_q != '0) begin
			cur_word = word_q;
			cur_rem  = rem_q;
		end else if (!qstat.empty) begin
			cur_word = head[WORD_BITS+NBW-1:NBW];
			cur_rem  = head[NBW-1:0];
		end else begin
			cur_word = word_q;
			cur_rem  = '0;
		end
		emit = advance && (cur_rem != '0);
		last = (cur_rem == NBW'(1));
		pop  = emit && (rem_q == '0);
	end

	// byte serialiser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (emit) begin
				rem_q <= NBW'(cur_rem - NBW'(1));
			end
			if (advance) begin
				ov_q <= emit;
			end
		end
	end

	// payload, high byte first
	always_ff @(posedge clk) begin
		if (emit) begin
			word_q <= cur_word << BYTE_BITS;
			byte_q <= cur_word[WORD_BITS-1 -: BYTE_BITS];
			last_q <= last;
		end
	end

	`include "msb_first_bit_packer_assert.svh"

	`BPK_ASSERT_NEXT(a_last_drains, emit && last, rem_q == '0)
	`BPK_ASSERT_NOW(a_rem_bound, rem_q != '0, rem_q < NBW'(NBYTES))

endmodule

// ===== rtl/msb_first_bit_packer.sv =====
// MSB-first variable-length bit packer. Each write word appends the low
// code_width bits of code_value (width clipped to 32, zero width ignored) to a
// WORD_BITS accumulator, top bit first; when a write would take the fill past
// WORD_BITS the completed word leaves as WORD_BITS/8 bytes, high byte first,
// and the leftover code bits start the next word. A flush word sends the bytes
// that hold valid bits and clears the packer. last_byte marks the final byte
// caused by one input word. Input words are accepted one per cycle while the
// two-entry job queue between the packing front end and the byte serialiser
// has room. The serialiser sends one byte per cycle while the receiver is
// ready, so sustained throughput is set by that byte serialiser. WORD_BITS
// must be a multiple of 8 and at least 32; the block does not check this.
module msb_first_bit_packer import bpk_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	bpk_in_if.sink    codes,
	bpk_out_if.source stream
);

	localparam int NBW = $clog2(WORD_BITS / BYTE_BITS + 1);
	localparam int JW  = WORD_BITS + NBW;

	logic          push;
	logic          pop;
	logic [JW-1:0] job;
	logic [JW-1:0] head;
	qstat_t        qstat;

	// packing front end
	bpk_front #(
		.WORD_BITS (WORD_BITS),
		.NBW       (NBW)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.codes  (codes),
		.qstat  (qstat),
		.push   (push),
		.job    (job)
	);

	// job queue between the two halves
	bpk_queue #(
		.W     (JW),
		.DEPTH (2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job),
		.pop    (pop),
		.rdata  (head),
		.qstat  (qstat)
	);

	// byte serialiser
	bpk_back #(
		.WORD_BITS (WORD_BITS),
		.NBW       (NBW)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.stream (stream)
	);

endmodule

// ===== bench/msb_first_bit_packer_tb.sv =====
`timescale 1ns / 1ps

module msb_first_bit_packer_tb import bpk_pkg::*; ();

	localparam int WORD_BITS      = 32;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int END_SETTLE     = 20;

	typedef struct {
		op_t                   op;
		logic [CODE_BITS-1:0]  value;
		logic [WIDTH_BITS-1:0] width;
	} code_word_t;

	typedef struct {
		logic [BYTE_BITS-1:0] data;
		logic                 last;
	} packed_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// source side, every input known from time zero
	logic                  drv_valid = 1'b0;
	op_t                   drv_op = OP_WRITE;
	logic [CODE_BITS-1:0]  drv_value = '0;
	logic [WIDTH_BITS-1:0] drv_width = '0;
	logic                  sink_ready = 1'b0;

	code_word_t   pending_codes[$];
	packed_byte_t expected_bytes[$];
	code_word_t   next_word;
	packed_byte_t wanted_byte;

	// packer state as the predictor sees it
	logic [WORD_BITS-1:0] pack_acc;
	int unsigned          pack_fill;

	int  src_gap;
	int  sink_gap;
	int  hold_left;
	int  hold_requests;
	int  holds_served;
	bit  steady_phase;

	int  words_in;
	int  flushes_in;
	int  bytes_checked;
	int  fault_count;
	int  idle_cycles;

	bpk_in_if  codes ();
	bpk_out_if stream ();

	assign codes.valid      = drv_valid;
	assign codes.operation  = drv_op;
	assign codes.code_value = drv_value;
	assign codes.code_width = drv_width;
	assign stream.ready     = sink_ready;

	msb_first_bit_packer #(.WORD_BITS(WORD_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.codes  (codes),
		.stream (stream)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bytes of a packing register, high byte first, last flag on the final one
	function automatic void queue_packed_bytes(logic [WORD_BITS-1:0] acc, int unsigned count);
		for (int k = 0; k < count; k++) begin
			expected_bytes.push_back('{acc[WORD_BITS-1-8*k -: 8], (k + 1 == count)});
		end
	endfunction

	// expected bytes for one accepted word, updating the predicted state
	function automatic void predict_packed_bytes(op_t op, logic [CODE_BITS-1:0] value,
			logic [WIDTH_BITS-1:0] width);
		int unsigned w;
		logic [63:0] code;
		if (op == OP_FLUSH) begin
			queue_packed_bytes(pack_acc, (pack_fill + 7) / 8);
			pack_acc  = '0;
			pack_fill = 0;
		end else begin
			w = (width > CODE_MAX) ? CODE_MAX : width;
			if (w != 0) begin
				code = {32'b0, value} & ((64'd1 << w) - 64'd1);
				pack_fill += w;
				// code spills over: top part completes the register
				if (pack_fill > WORD_BITS) begin
					pack_fill -= WORD_BITS;
					pack_acc |= WORD_BITS'(code >> pack_fill);
					queue_packed_bytes(pack_acc, WORD_BITS / 8);
					pack_acc = '0;
				end
				pack_acc |= WORD_BITS'(code << (WORD_BITS - pack_fill));
			end
		end
	endfunction

	// mostly lzw-like widths with occasional flushes, zero and over-wide widths
	function automatic code_word_t random_code_word();
		code_word_t  cw;
		int unsigned pick;
		cw.op    = OP_WRITE;
		cw.value = $urandom();
		cw.width = WIDTH_BITS'($urandom_range(9, 16));
		pick     = $urandom_range(0, 99);
		if (pick < 8) begin
			cw.op    = OP_FLUSH;
			cw.width = WIDTH_BITS'($urandom());
		end else if (pick < 12) begin
			cw.width = '0;
		end else if (pick < 16) begin
			cw.width = WIDTH_BITS'($urandom_range(33, 63));
		end else if (pick < 30) begin
			cw.width = WIDTH_BITS'($urandom_range(17, 32));
		end else if (pick < 45) begin
			cw.width = WIDTH_BITS'($urandom_range(1, 8));
		end
		return cw;
	endfunction

	function automatic void add_word(op_t op, logic [CODE_BITS-1:0] value,
			logic [WIDTH_BITS-1:0] width);
		pending_codes.push_back('{op, value, width});
	endfunction

	function automatic void add_random_words(int count);
		for (int i = 0; i < count; i++) begin
			pending_codes.push_back(random_code_word());
		end
	endfunction

	// returns once every queued word is sent, every expected byte has arrived and no idle burst runs
	task automatic wait_drained();
		while (pending_codes.size() != 0 || drv_valid || expected_bytes.size() != 0 ||
				src_gap != 0 || sink_gap != 0) begin
			@(negedge clk);
		end
	endtask

	// code word driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_op    <= OP_WRITE;
			drv_value <= '0;
			drv_width <= '0;
			src_gap   <= 0;
		end else if (!drv_valid || codes.ready) begin
			if (src_gap > 0) begin
				drv_valid <= 1'b0;
				src_gap   <= src_gap - 1;
			end else if (!steady_phase && $urandom_range(0, 11) == 0) begin
				drv_valid <= 1'b0;
				src_gap   <= $urandom_range(0, 15);
			end else if (pending_codes.size() != 0) begin
				next_word = pending_codes.pop_front();
				drv_valid <= 1'b1;
				drv_op    <= next_word.op;
				drv_value <= next_word.value;
				drv_width <= next_word.width;
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// byte receiver with random stalls and one long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_ready   <= 1'b0;
			sink_gap     <= 0;
			hold_left    <= 0;
			holds_served <= 0;
		end else if (holds_served != hold_requests) begin
			holds_served <= hold_requests;
			hold_left    <= LONG_HOLD - 1;
			sink_ready   <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left  <= hold_left - 1;
			sink_ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap   <= sink_gap - 1;
			sink_ready <= 1'b0;
		end else if (!steady_phase && $urandom_range(0, 9) == 0) begin
			sink_gap   <= $urandom_range(0, 15);
			sink_ready <= 1'b0;
		end else begin
			sink_ready <= 1'b1;
		end
	end

	// monitor: predict on accepted code words, check accepted bytes, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (codes.valid && codes.ready) begin
				words_in++;
				if (codes.operation == OP_FLUSH)
					flushes_in++;
				predict_packed_bytes(codes.operation, codes.code_value, codes.code_width);
			end
			if (stream.valid && stream.ready) begin
				bytes_checked++;
				if (expected_bytes.size() == 0) begin
					if (fault_count < 10)
						$display("unexpected byte %02h last %0b at %0t",
							stream.out_byte, stream.last_byte, $realtime);
					fault_count++;
				end else begin
					wanted_byte = expected_bytes.pop_front();
					if (stream.out_byte !== wanted_byte.data ||
							stream.last_byte !== wanted_byte.last) begin
						if (fault_count < 10)
							$display("byte %0d: expected %02h last %0b, got %02h last %0b",
								bytes_checked, wanted_byte.data, wanted_byte.last,
								stream.out_byte, stream.last_byte);
						fault_count++;
					end
				end
			end
			if ((codes.valid && codes.ready) || (stream.valid && stream.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("no handshake for %0d cycles, %0d bytes still expected",
					WATCHDOG_LIMIT, expected_bytes.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		pack_acc      = '0;
		pack_fill     = 0;
		hold_requests = 0;
		steady_phase  = 1'b0;
		words_in      = 0;
		flushes_in    = 0;
		bytes_checked = 0;
		fault_count   = 0;
		idle_cycles   = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero width, empty flush, exact fill, clipping, 1 to 4 byte flushes
		add_word(OP_WRITE, 32'hFFFF_FFFF, 6'd0);
		add_word(OP_FLUSH, 32'h0000_0000, 6'd0);
		add_word(OP_WRITE, 32'hFFFF_FFFF, 6'd32);
		add_word(OP_WRITE, 32'h0000_0000, 6'd1);
		add_word(OP_FLUSH, 32'hFFFF_FFFF, 6'd63);
		add_word(OP_WRITE, 32'hDEAD_BEEF, 6'd4);
		add_word(OP_WRITE, 32'h0001_2345, 6'd63);
		add_word(OP_WRITE, 32'h0000_0000, 6'd33);
		add_word(OP_FLUSH, 32'h0000_0000, 6'd0);
		add_word(OP_WRITE, 32'h0000_0081, 6'd8);
		add_word(OP_FLUSH, 32'h0000_0000, 6'd0);
		add_word(OP_WRITE, 32'hFFFF_F3FF, 6'd10);
		add_word(OP_FLUSH, 32'h0000_0000, 6'd0);
		add_word(OP_WRITE, 32'h0000_0005, 6'd3);
		add_word(OP_WRITE, 32'h5555_AAAA, 6'd16);
		add_word(OP_FLUSH, 32'h0000_0000, 6'd0);
		add_word(OP_WRITE, 32'h001A_BCDE, 6'd24);
		add_word(OP_WRITE, 32'h0000_0001, 6'd1);
		add_word(OP_FLUSH, 32'h0000_0000, 6'd0);
		add_word(OP_WRITE, 32'hA5A5_A5A5, 6'd32);
		add_word(OP_FLUSH, 32'h0000_0000, 6'd0);
		add_word(OP_WRITE, 32'h0000_0000, 6'd32);
		add_word(OP_WRITE, 32'hFFFF_FFFF, 6'd40);
		add_word(OP_WRITE, 32'h0000_0000, 6'd0);
		add_word(OP_FLUSH, 32'h0000_0000, 6'd0);
		wait_drained();

		// random traffic with idling on both sides
		add_random_words(110);
		wait_drained();

		// long receiver hold while the sender keeps offering words
		hold_requests++;
		add_random_words(40);
		wait_drained();

		add_random_words(125);
		wait_drained();

		// closing stretch at full rate
		steady_phase = 1'b1;
		add_random_words(60);
		add_word(OP_FLUSH, 32'h0000_0000, 6'd0);
		wait_drained();
		repeat (END_SETTLE) @(posedge clk);

		if (expected_bytes.size() != 0) begin
			if (fault_count < 10)
				$display("%0d expected bytes never arrived", expected_bytes.size());
			fault_count++;
		end
		$display("packed %0d code words (%0d flushes) into %0d checked bytes",
			words_in, flushes_in, bytes_checked);
		$display("random stalls both sides, a %0d-cycle output hold and a full-rate tail",
			LONG_HOLD);
		if (fault_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bpk_pkg.sv
rtl/bpk_in_if.sv
rtl/bpk_out_if.sv
rtl/bpk_queue.sv
rtl/bpk_front.sv
rtl/bpk_back.sv
rtl/msb_first_bit_packer.sv
bench/msb_first_bit_packer_tb.sv
